>>> sv/slcd_pkg.sv
// slcd_pkg: shared request codes, lcd byte constants and control/status structs
// for the scrolling line lcd controller; depends on nothing
package slcd_pkg;

  // request codes
  localparam logic [2:0] CMD_SCROLL  = 3'd0;
  localparam logic [2:0] CMD_CLEAR   = 3'd1;
  localparam logic [2:0] CMD_PUT     = 3'd2;
  localparam logic [2:0] CMD_CURSOR  = 3'd3;
  localparam logic [2:0] CMD_VISIBLE = 3'd4;

  // hd44780 bytes
  localparam logic [7:0] LCD_HOME       = 8'h80;
  localparam logic [7:0] LCD_ERASE_ALL  = 8'h01;
  localparam logic [7:0] LCD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] LCD_SPACE      = 8'h20;

  // controller to datapath
  typedef struct packed {
    logic store_char;   // write scroll char into the line
    logic clear_line;   // empty the line
    logic load_single;  // load a one-byte result from the request
    logic load_home;    // load cursor-home byte, start line read
    logic load_data;    // load one data byte of the line
  } slcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a byte this cycle
    logic data_last;  // current data byte is the last of the line
  } slcd_sts_t;

endpackage

>>> sv/scrolling_line_lcd_controller.sv
// scrolling_line_lcd_controller: top level, joins the scan controller and the datapath
// depends on slcd_pkg, slcd_ctrl and slcd_dp
//
// Turns requests into hd44780 byte transfers, one result transfer per byte, with
// is_data as register select and last marking the final byte of a request. Put char,
// set cursor, cursor visibility and clear each give one byte: the request is accepted
// and its byte is loaded into the output register in the same cycle. Scroll char
// writes the character into a LINE_WIDTH-entry line memory (append while not full,
// else overwrite the oldest entry and advance the ring head), then sends
// cursor-home and LINE_WIDTH data bytes. The accept and memory write come first, then
// one byte per cycle, paced by the single registered read port of the line memory.
// No new request is taken until the last data byte of a scroll is in the output register.
// Unused command codes are accepted and give no transfer. Output backpressure
// stretches everything cycle for cycle. There is no clearing pass: entries beyond the
// fill count are never shown, they read as spaces.
module scrolling_line_lcd_controller #(
  parameter int LINE_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [7:0] char_code_i,
  input  logic [5:0] column_i,
  input  logic       row_i,
  input  logic       visible_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_data_o,
  output logic [7:0] lcd_byte_o,
  output logic       last_o
);
  import slcd_pkg::*;

  slcd_cmd_t cmd;
  slcd_sts_t sts;

  // request decode and scan sequencing
  slcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // line memory and output register
  slcd_dp #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .visible_i   (visible_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_data_o   (is_data_o),
    .lcd_byte_o  (lcd_byte_o),
    .last_o      (last_o)
  );

  // only one source loads the output register in a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_single, cmd.load_home, cmd.load_data}))
    else $error("more than one output load in a cycle");

  // a scroll blocks new requests while its line is sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store_char |=> !in_ready_o)
    else $error("request taken during scroll");

  // cursor-home opens every line transfer and is never the last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_home |=> out_valid_o && !is_data_o && (lcd_byte_o == LCD_HOME) && !last_o)
    else $error("bad cursor-home transfer");

  // the final data byte of the line closes the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_data && sts.data_last |=> out_valid_o && is_data_o && last_o)
    else $error("line end not marked last");

endmodule

>>> sv/slcd_ctrl.sv
// slcd_ctrl: request decode and line scan state machine
// depends on slcd_pkg
module slcd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          command_i,
  input  slcd_pkg::slcd_sts_t sts_i,
  output slcd_pkg::slcd_cmd_t cmd_o
);
  import slcd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HOME = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    unique case (command_i) inside
      CMD_SCROLL: begin
        cmd_o.store_char = accept;
      end
      CMD_CLEAR: begin
        cmd_o.clear_line  = accept;
        cmd_o.load_single = accept;
      end
      CMD_PUT, CMD_CURSOR, CMD_VISIBLE: begin
        cmd_o.load_single = accept;
      end
      default: begin
        // unused codes are taken and dropped
      end
    endcase
    cmd_o.load_home = (state_q == ST_HOME) && sts_i.out_free;
    cmd_o.load_data = (state_q == ST_DATA) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.store_char) state_d = ST_HOME;
      end
      ST_HOME: begin
        if (cmd_o.load_home) state_d = ST_DATA;
      end
      ST_DATA: begin
        if (cmd_o.load_data && sts_i.data_last) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/slcd_dp.sv
// slcd_dp: line memory, fill count, ring head, read pointer and output register
// depends on slcd_pkg
module slcd_dp #(
  parameter int LINE_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          command_i,
  input  logic [7:0]          char_code_i,
  input  logic [5:0]          column_i,
  input  logic                row_i,
  input  logic                visible_i,
  input  slcd_pkg::slcd_cmd_t cmd_i,
  output slcd_pkg::slcd_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                is_data_o,
  output logic [7:0]          lcd_byte_o,
  output logic                last_o
);
  import slcd_pkg::*;

  localparam int AW = $clog2(LINE_WIDTH);
  localparam int FW = $clog2(LINE_WIDTH + 1);

  logic [7:0]    mem [LINE_WIDTH];
  logic [7:0]    rdata_q;
  logic [FW-1:0] fill_q;
  logic [AW-1:0] head_q;
  logic [AW-1:0] ptr_q;
  logic [AW-1:0] idx_q;
  logic          full;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] head_next;
  logic [AW-1:0] ptr_next;
  logic [AW-1:0] ptr_start_next;
  logic          out_valid_q;
  logic          is_data_q;
  logic [7:0]    byte_q;
  logic          last_q;
  logic          single_is_data;
  logic [7:0]    single_byte;
  logic [7:0]    data_byte;
  logic          load;

  assign full    = (fill_q == FW'(LINE_WIDTH));
  assign wr_addr = full ? head_q : fill_q[AW-1:0];

  assign head_next      = (head_q == AW'(LINE_WIDTH - 1)) ? '0 : head_q + 1'b1;
  assign ptr_next       = (ptr_q == AW'(LINE_WIDTH - 1)) ? '0 : ptr_q + 1'b1;
  assign ptr_start_next = head_next;

  // memory write port and registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_char) begin
      mem[wr_addr] <= char_code_i;
    end
    if (cmd_i.load_home) begin
      rdata_q <= mem[head_q];
    end else if (cmd_i.load_data) begin
      rdata_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      head_q <= '0;
      ptr_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.clear_line) begin
        fill_q <= '0;
        head_q <= '0;
      end else if (cmd_i.store_char) begin
        if (full) head_q <= head_next;
        else      fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.load_home) begin
        ptr_q <= ptr_start_next;
        idx_q <= '0;
      end else if (cmd_i.load_data) begin
        ptr_q <= ptr_next;
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // one-byte results
  always_comb begin
    single_is_data = 1'b0;
    single_byte    = 8'h00;
    unique case (command_i)
      CMD_CLEAR:   single_byte = LCD_ERASE_ALL;
      CMD_PUT: begin
        single_is_data = 1'b1;
        single_byte    = char_code_i;
      end
      CMD_CURSOR:  single_byte = {1'b1, row_i, column_i};
      CMD_VISIBLE: single_byte = LCD_DISPLAY_ON | {6'd0, visible_i, 1'b0};
      default:     single_byte = 8'h00;
    endcase
  end

  // unfilled entries and stored zero show as a space
  assign data_byte = (({{(FW - AW){1'b0}}, idx_q} < fill_q) && (rdata_q != 8'h00))
                     ? rdata_q : LCD_SPACE;

  assign load = cmd_i.load_single || cmd_i.load_home || cmd_i.load_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single) begin
      is_data_q <= single_is_data;
      byte_q    <= single_byte;
      last_q    <= 1'b1;
    end else if (cmd_i.load_home) begin
      is_data_q <= 1'b0;
      byte_q    <= LCD_HOME;
      last_q    <= 1'b0;
    end else if (cmd_i.load_data) begin
      is_data_q <= 1'b1;
      byte_q    <= data_byte;
      last_q    <= sts_o.data_last;
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.data_last = (idx_q == AW'(LINE_WIDTH - 1));

  assign out_valid_o = out_valid_q;
  assign is_data_o   = is_data_q;
  assign lcd_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule
